### rtl/error_diffusion_dither_top_macros.svh
// ----------------------------------------------------------------------------
// error_diffusion_dither_top_macros
// assertion macros shared by the dither rtl, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH

// same-cycle implication
`define EDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// types, constants and share arithmetic of the error diffusion dither
// ----------------------------------------------------------------------------
package edd_pkg;

    // configuration register width and defaults
    localparam int CFG_W          = 13;
    localparam int DEF_WIDTH      = 640;
    localparam int DEF_HEIGHT     = 480;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_W          = 12;

    // gray conversion in 16-bit fixed point
    localparam int GSUM_W         = 25;
    localparam int COEF_R         = 19595;
    localparam int COEF_G         = 38470;
    localparam int COEF_B         = 7471;
    localparam int GRAY_ROUND     = 32768;

    // level limits
    localparam logic [7:0] WHITE_THRESH = 8'd128;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // 9-bit signed diffusion error
    typedef logic signed [8:0] t_err;

    // 8-bit signed share of an error
    typedef logic signed [7:0] t_share;

    // floor(e/4 + 1/2)
    function automatic t_share quarter_share(input t_err e);
        logic signed [9:0] t;
        t = {e[8], e} + 10'sd2;
        return t[9:2];
    endfunction

    // floor(3e/8 + 1/2)
    function automatic t_share three_eighths_share(input t_err e);
        logic signed [11:0] ex;
        logic signed [11:0] t;
        ex = {{3{e[8]}}, e};
        t  = (ex <<< 1) + ex + 12'sd4;
        return t[10:3];
    endfunction

    // add a share to a level and clamp to 0..255
    function automatic logic [7:0] clamp_add(input logic [7:0] v, input t_share s);
        logic signed [9:0] sum;
        sum = $signed({2'b00, v}) + {{2{s[7]}}, s};
        if (sum < 10'sd0) begin
            return 8'd0;
        end else if (sum > $signed({2'b00, LEVEL_MAX})) begin
            return LEVEL_MAX;
        end else begin
            return sum[7:0];
        end
    endfunction

    // error left after thresholding
    function automatic t_err level_err(input logic [7:0] v);
        if (v > WHITE_THRESH) begin
            return $signed({1'b0, v}) - $signed({1'b0, LEVEL_MAX});
        end else begin
            return $signed({1'b0, v});
        end
    endfunction

endpackage

### rtl/edd_line_store.sv
// ----------------------------------------------------------------------------
// edd_line_store
// one-row error memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module edd_line_store import edd_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_err          o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_err          i_wr_data
);

    t_err mem [DEPTH];
    t_err r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/error_diffusion_dither_top.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_top
// a pixel passes the stage 1, 2 and 3 registers and then the output register
// throughput: one pixel per cycle for image widths of four or more while the
//   output is not stalled; the line store is written at stage 3 and a pixel waits
//   while an earlier one of the same column is in flight, so widths 1..3 run slower
// reset: synchronous active low; counters and carried errors clear, the
//   registers return to 640 x 480; the line store keeps its contents
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_top_macros.svh"

module error_diffusion_dither_top import edd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // pixel input
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // dithered output
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // white[0], adjusted_level[8:1], zero[15:9]
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;

    // configuration registers
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    // position of the next pixel
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // stage 1: color and line store read
    logic             r_s1_valid;
    logic [7:0]       r_s1_red;
    logic [7:0]       r_s1_green;
    logic [7:0]       r_s1_blue;
    logic [CW-1:0]    r_s1_col;
    logic             r_s1_up;
    logic             r_s1_left;
    t_err             r_ul;
    t_err             above_rd;

    // stage 2: gray with diagonal and upper shares
    logic             r_s2_valid;
    logic [7:0]       r_s2_gray;
    t_share           r_s2_ul_share;
    t_share           r_s2_ab_share;
    logic [CW-1:0]    r_s2_col;
    logic             r_s2_left;

    // stage 3: left share, threshold, write back
    logic             r_s3_valid;
    logic [7:0]       r_s3_level;
    logic [CW-1:0]    r_s3_col;
    logic             r_s3_left;
    t_err             r_left_err;

    // output register
    logic             r_o_valid;
    logic             r_o_white;
    logic [7:0]       r_o_level;

    // flow control
    logic             o_load;
    logic             s3_go;
    logic             s3_free;
    logic             s2_go;
    logic             s2_free;
    logic             s1_go;
    logic             s1_free;
    logic             hazard;
    logic             accept;

    // combinational stage results
    logic [GSUM_W-1:0] gsum;
    t_share           ul_share;
    t_share           ab_share;
    logic [7:0]       s2_level;
    t_share           left_share;
    logic [7:0]       s3_level;
    t_err             s3_err;

    // effective frame size and counter steps
    logic [CMPW-1:0]  width_ext;
    logic [CMPW-1:0]  width_eff;
    logic [CMPW-1:0]  col_nxt;
    logic [CFG_W-1:0] height_eff;
    logic [CFG_W-1:0] row_nxt;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(DEF_WIDTH);
            r_image_height <= CFG_W'(DEF_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance, back to front
    assign o_load  = !r_o_valid || i_m_axis_tready;
    assign s3_go   = r_s3_valid && o_load;
    assign s3_free = !r_s3_valid || s3_go;
    assign s2_go   = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s2_go;
    assign s1_go   = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s1_go;

    // hold a pixel whose column is still waiting for its write back
    assign hazard = (r_s1_valid && (r_s1_col == r_col))
                 || (r_s2_valid && (r_s2_col == r_col))
                 || (r_s3_valid && (r_s3_col == r_col));

    assign o_s_axis_tready = s1_free && !hazard;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // frame size, zero acts as one, oversize saturates
    assign width_ext = CMPW'(r_image_width);

    always_comb begin
        if (r_image_width == '0) begin
            width_eff = CMPW'(1);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            width_eff = CMPW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (r_image_height == '0) begin
            height_eff = CFG_W'(1);
        end else if (r_image_height > CFG_W'(MAX_HEIGHT)) begin
            height_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_image_height;
        end
    end

    assign col_nxt = CMPW'(r_col) + CMPW'(1);
    assign row_nxt = CFG_W'(r_row) + CFG_W'(1);

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_nxt >= width_eff) begin
                r_col <= '0;
                if (row_nxt >= height_eff) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_nxt[ROW_W-1:0];
                end
            end else begin
                r_col <= col_nxt[CW-1:0];
            end
        end
    end

    // line store of the previous row's errors
    edd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (above_rd),
        .i_wr_en   (s3_go),
        .i_wr_addr (r_s3_col),
        .i_wr_data (s3_err)
    );

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_red   <= i_s_axis_tdata[7:0];
            r_s1_green <= i_s_axis_tdata[15:8];
            r_s1_blue  <= i_s_axis_tdata[23:16];
            r_s1_col   <= r_col;
            r_s1_up    <= (r_row != '0);
            r_s1_left  <= (r_col != '0);
        end
    end

    // above error of the previous pixel becomes the diagonal error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul <= '0;
        end else if (s1_go) begin
            r_ul <= above_rd;
        end
    end

    // gray conversion and upper shares
    assign gsum = GSUM_W'(r_s1_red)   * GSUM_W'(COEF_R)
                + GSUM_W'(r_s1_green) * GSUM_W'(COEF_G)
                + GSUM_W'(r_s1_blue)  * GSUM_W'(COEF_B)
                + GSUM_W'(GRAY_ROUND);

    assign ul_share = (r_s1_up && r_s1_left) ? quarter_share(r_ul) : '0;
    assign ab_share = r_s1_up ? three_eighths_share(above_rd) : '0;

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_gray     <= gsum[23:16];
            r_s2_ul_share <= ul_share;
            r_s2_ab_share <= ab_share;
            r_s2_col      <= r_s1_col;
            r_s2_left     <= r_s1_left;
        end
    end

    // diagonal then upper correction, each clamped
    assign s2_level = clamp_add(clamp_add(r_s2_gray, r_s2_ul_share), r_s2_ab_share);

    // stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= s2_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s3_level <= s2_level;
            r_s3_col   <= r_s2_col;
            r_s3_left  <= r_s2_left;
        end
    end

    // left correction from the error just produced
    assign left_share = r_s3_left ? three_eighths_share(r_left_err) : '0;
    assign s3_level   = clamp_add(r_s3_level, left_share);
    assign s3_err     = level_err(s3_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_err <= '0;
        end else if (s3_go) begin
            r_left_err <= s3_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= s3_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_o_white <= (s3_level > WHITE_THRESH);
            r_o_level <= s3_level;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {7'd0, r_o_level, r_o_white};

    // checks
    `EDD_ASSERT_IMP(a_s1_s2_col, r_s1_valid && r_s2_valid, r_s1_col != r_s2_col, "stage 1 and 2 share a column")
    `EDD_ASSERT_IMP(a_s1_s3_col, r_s1_valid && r_s3_valid, r_s1_col != r_s3_col, "stage 1 and 3 share a column")
    `EDD_ASSERT_IMP(a_col_range, 1'b1, CMPW'(r_col) < CMPW'(MAX_WIDTH), "column beyond line store")
    `EDD_ASSERT_NXT(a_s3_out, s3_go, r_o_valid && (r_o_white == (r_o_level > WHITE_THRESH)), "result lost or bad")

endmodule

### tb/error_diffusion_dither_top_tb.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_top_tb
// self-checking bench for the error diffusion dither: pixels go in on the
// input stream, each output transaction is compared with a bit-exact gray,
// diffusion and threshold predictor kept alongside, under random stalls on
// both sides, frame sizes from 1x1 up to oversize, and register changes
// taken between bursts of pixels
// ----------------------------------------------------------------------------
module error_diffusion_dither_top_tb;
    import edd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int STORE_COLS    = DEF_MAX_WIDTH;
    localparam int PRIMED_COLS   = 64;

    // pixel as packed on the input stream, red in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // one dithered result
    typedef struct packed {
        logic       white;
        logic [7:0] level;
    } dither_px_t;

    // content styles for random bursts
    typedef enum int {
        SHADE_UNIFORM,
        SHADE_EXTREME,
        SHADE_MIDGRAY,
        SHADE_DARK,
        SHADE_BRIGHT,
        SHADE_RAMP
    } shade_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             pix_valid  = 1'b0;
    rgb_t             pix_data   = '0;
    logic             dith_ready = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic [0:0]       cfg_index  = '0;
    logic [CFG_W-1:0] cfg_data   = '0;

    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [15:0]      o_m_axis_tdata;
    logic             o_cfg_ready;

    // predictor state
    logic [CFG_W-1:0] frame_w = CFG_W'(DEF_WIDTH);
    logic [CFG_W-1:0] frame_h = CFG_W'(DEF_HEIGHT);
    int               col_pos = 0;
    int               row_pos = 0;
    t_err             line_err [STORE_COLS];
    t_err             left_err   = '0;
    t_err             upleft_err = '0;

    dither_px_t       dither_expect_q [$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               tx_idle_pct    = 0;
    int               rx_idle_pct    = 0;
    int               hold_req       = 0;
    int               hold_left      = 0;

    error_diffusion_dither_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (pix_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (dith_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("error_diffusion_dither_top test failed");
            $finish;
        end
    end

    function automatic int clip_level(input int v);
        if (v < 0) begin
            return 0;
        end else if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    // gray, diffusion from three neighbors, threshold; advances the raster position
    function automatic dither_px_t dither_predict(input rgb_t px);
        int         eff_w;
        int         eff_h;
        int         lvl;
        int         err;
        t_err       above;
        dither_px_t res;
        eff_w = (frame_w == 0) ? 1 : (frame_w > STORE_COLS) ? STORE_COLS : int'(frame_w);
        eff_h = (frame_h == 0) ? 1 : (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
        lvl = (COEF_R * int'(px.red) + COEF_G * int'(px.green) + COEF_B * int'(px.blue)
               + GRAY_ROUND) >>> 16;
        above = line_err[col_pos];
        // shares round half up: floor(k*e + 1/2)
        if (row_pos > 0 && col_pos > 0) begin
            lvl = clip_level(lvl + ((int'(upleft_err) + 2) >>> 2));
        end
        if (row_pos > 0) begin
            lvl = clip_level(lvl + ((3 * int'(above) + 4) >>> 3));
        end
        if (col_pos > 0) begin
            lvl = clip_level(lvl + ((3 * int'(left_err) + 4) >>> 3));
        end
        err = (lvl <= 128) ? lvl : lvl - 255;
        upleft_err        = above;
        line_err[col_pos] = t_err'(err);
        left_err          = t_err'(err);
        res.white = (lvl > 128);
        res.level = 8'(lvl);
        col_pos++;
        if (col_pos >= eff_w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= eff_h) begin
                row_pos = 0;
            end
        end
        return res;
    endfunction

    // compare one output transaction with the oldest expectation
    task automatic check_dither(input logic [15:0] tdata);
        dither_px_t want;
        if (dither_expect_q.size() == 0) begin
            $error("unexpected result: white %0d adjusted_level %0d", tdata[0], tdata[8:1]);
            mismatch_count++;
        end else begin
            want = dither_expect_q.pop_front();
            if (tdata[0] !== want.white) begin
                $error("white: expected %0d, actual %0d", want.white, tdata[0]);
                mismatch_count++;
            end
            if (tdata[8:1] !== want.level) begin
                $error("adjusted_level: expected %0d, actual %0d", want.level, tdata[8:1]);
                mismatch_count++;
            end
        end
    endtask

    // output side: check accepted results, then pick next ready
    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && dith_ready) begin
            check_dither(o_m_axis_tdata);
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            dith_ready <= 1'b0;
        end else begin
            dith_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one input transaction, with a random gap in front
    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        do @(posedge clk); while (!o_s_axis_tready);
        dither_expect_q.push_back(dither_predict(px));
    endtask

    // stop offering pixels until every result is back
    task automatic wait_drained();
        pix_valid <= 1'b0;
        do @(posedge clk); while (dither_expect_q.size() != 0);
    endtask

    // one register transaction; valid stays up for a following write
    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == REG_IMAGE_WIDTH) begin
            frame_w = val;
        end else begin
            frame_h = val;
        end
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_one(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_write(idx, val);
        cfg_valid <= 1'b0;
    endtask

    function automatic rgb_t make_rgb(input int r, input int g, input int b);
        rgb_t px;
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        return px;
    endfunction

    function automatic rgb_t shade_pixel(input shade_t shade, input int k);
        int v;
        case (shade)
            SHADE_EXTREME: begin
                return make_rgb(255 * $urandom_range(1), 255 * $urandom_range(1),
                                255 * $urandom_range(1));
            end
            SHADE_MIDGRAY: begin
                v = $urandom_range(100, 160);
                return make_rgb(v ^ $urandom_range(1), v, v ^ $urandom_range(1));
            end
            SHADE_DARK: begin
                return make_rgb($urandom_range(30), $urandom_range(30), $urandom_range(30));
            end
            SHADE_BRIGHT: begin
                return make_rgb($urandom_range(225, 255), $urandom_range(225, 255),
                                $urandom_range(225, 255));
            end
            SHADE_RAMP: begin
                v = (k * 7) & 255;
                return make_rgb(v, v, v);
            end
            default: begin
                return make_rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
        endcase
    endfunction

    // widths stay inside the primed columns of the line store
    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(7))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(2);
            3: return CFG_W'(3);
            4: return CFG_W'(PRIMED_COLS);
            default: return CFG_W'($urandom_range(4, 40));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        case ($urandom_range(6))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(MAX_HEIGHT);
            3: return {CFG_W{1'b1}};
            default: return CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_wide_width();
        case ($urandom_range(4))
            0: return CFG_W'(STORE_COLS);
            1: return {CFG_W{1'b1}};
            2: return CFG_W'(STORE_COLS + 1);
            default: return CFG_W'($urandom_range(PRIMED_COLS + 1, STORE_COLS - 1));
        endcase
    endfunction

    // a 1x1 frame wraps the raster position back to the origin in one pixel
    task automatic align_to_origin();
        set_frame(CFG_W'(1), CFG_W'(1));
        send_pixel(shade_pixel(SHADE_UNIFORM, 0));
    endtask

    // default 640x480 after reset, color extremes and the white threshold
    task automatic test_color_extremes();
        send_pixel(make_rgb(0, 0, 0));
        send_pixel(make_rgb(255, 255, 255));
        send_pixel(make_rgb(255, 0, 0));
        send_pixel(make_rgb(0, 255, 0));
        send_pixel(make_rgb(0, 0, 255));
        send_pixel(make_rgb(128, 128, 128));
        send_pixel(make_rgb(129, 129, 129));
    endtask

    // 3x2 frames: row and frame edges, clamping at both ends
    task automatic test_frame_edges();
        int k;
        set_frame(CFG_W'(3), CFG_W'(2));
        for (k = 0; k < 9; k++) begin
            send_pixel((k % 2 == 0) ? make_rgb(255, 255, 255) : make_rgb(0, 0, 0));
        end
    endtask

    // width and height of zero behave as one
    task automatic test_zero_size();
        set_frame(CFG_W'(0), CFG_W'(0));
        send_pixel(make_rgb(90, 90, 90));
        send_pixel(make_rgb(200, 200, 200));
        send_pixel(make_rgb(90, 90, 90));
    endtask

    // all-ones registers behave as the largest frame
    task automatic test_oversize();
        set_frame({CFG_W{1'b1}}, {CFG_W{1'b1}});
        send_pixel(make_rgb(140, 140, 140));
        send_pixel(make_rgb(60, 60, 60));
        send_pixel(make_rgb(180, 20, 240));
    endtask

    // narrow the row while the counters are past the new width
    task automatic test_mid_frame_change();
        set_one(REG_IMAGE_WIDTH, CFG_W'(2));
        send_pixel(make_rgb(100, 150, 200));
        send_pixel(make_rgb(130, 130, 130));
        send_pixel(make_rgb(250, 5, 30));
        send_pixel(make_rgb(70, 70, 70));
    endtask

    // single-row frame writes every column read by the random frames
    task automatic test_line_store_prime();
        int k;
        align_to_origin();
        set_frame(CFG_W'(PRIMED_COLS), CFG_W'(1));
        for (k = 0; k < PRIMED_COLS; k++) begin
            send_pixel(shade_pixel(SHADE_UNIFORM, k));
        end
    endtask

    // bursts of pixels, each under a fresh frame setting
    task automatic test_random_frames(input int n_items);
        int     sent;
        int     len;
        int     k;
        shade_t shade;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: begin
                    // wide rows only in single-row frames, so no unprimed column is read
                    if (row_pos != 0) begin
                        align_to_origin();
                        sent++;
                    end
                    set_frame(pick_wide_width(), CFG_W'($urandom_range(1)));
                end
                1, 2: begin
                    if (frame_w > CFG_W'(PRIMED_COLS)) begin
                        set_frame(pick_width(), pick_height());
                    end else if ($urandom_range(1) != 0) begin
                        set_one(REG_IMAGE_WIDTH, pick_width());
                    end else begin
                        set_one(REG_IMAGE_HEIGHT, pick_height());
                    end
                end
                default: begin
                    set_frame(pick_width(), pick_height());
                end
            endcase
            shade = shade_t'($urandom_range(SHADE_RAMP));
            len   = $urandom_range(10, 90);
            for (k = 0; k < len; k++) begin
                send_pixel(shade_pixel(shade, k));
            end
            sent += len;
        end
    endtask

    // long output stall with the input kept busy until it backs up
    task automatic test_output_backpressure();
        int k;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_frame(CFG_W'(16), CFG_W'(4));
        hold_req = 400;
        for (k = 0; k < 80; k++) begin
            send_pixel(shade_pixel(SHADE_UNIFORM, k));
        end
        wait_drained();
    endtask

    initial begin
        tx_idle_pct = 32;
        rx_idle_pct = 84;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_color_extremes();
        test_frame_edges();
        test_zero_size();
        test_oversize();
        test_mid_frame_change();
        test_line_store_prime();
        test_random_frames(500);

        tx_idle_pct = 84;
        rx_idle_pct = 32;
        test_random_frames(500);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(500);

        test_output_backpressure();

        // let the pipeline settle so any stray result is caught
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("error_diffusion_dither_top test passed");
        end else begin
            $display("error_diffusion_dither_top test failed");
        end
        $finish;
    end

endmodule
